[design/bcf_pkg.sv]
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared widths, register indexes, state, command and status types for the
// crop box filter with per-axis RMS summary.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int NumAxes          = 3;
    localparam int CoordBits        = 16;
    localparam int HalfBits         = 15;
    localparam int CountBits        = 17;
    localparam int SumBits          = 47;
    localparam int IndexBits        = 16;
    localparam int RmsBits          = 16;
    localparam int MaxPointsDefault = 65536;
    localparam int CountCap         = 65536;

    // serial divide: one quotient bit per cycle; serial root: one root bit per cycle
    localparam int RootBits  = (SumBits + 1) / 2;
    localparam int DivSteps  = SumBits;
    localparam int SqrtSteps = RootBits;
    localparam int StepBits  = $clog2(DivSteps + 1);

    localparam int CfgAddrBits = 4;
    localparam int CfgDataBits = 32;
    localparam int RegIdxBits  = CfgAddrBits - 2;

    localparam logic [RegIdxBits-1:0] RegHalfX = 2'd0;
    localparam logic [RegIdxBits-1:0] RegHalfY = 2'd1;
    localparam logic [RegIdxBits-1:0] RegHalfZ = 2'd2;

    typedef enum logic [0:0] {
        KIND_INDEX   = 1'b0,
        KIND_SUMMARY = 1'b1
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_ACC,
        ST_DIV,
        ST_SQRT,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic push_index;
        logic acc;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic push_summary;
    } cmd_t;

    typedef struct packed {
        logic in_box;
        logic last;
        logic out_free;
        logic div_done;
        logic sqrt_done;
    } status_t;

endpackage

[design/bcf_point_if.sv]
// ----------------------------------------------------------------------------
// bcf_point_if
// Point stream channel: valid/ready handshake with three coordinates and an
// end-of-cloud mark.
// ----------------------------------------------------------------------------
interface bcf_point_if;
    import bcf_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [CoordBits-1:0] coord_x;
    logic signed [CoordBits-1:0] coord_y;
    logic signed [CoordBits-1:0] coord_z;
    logic                        end_of_cloud;

    modport source (
        output valid, coord_x, coord_y, coord_z, end_of_cloud,
        input  ready
    );

    modport sink (
        input  valid, coord_x, coord_y, coord_z, end_of_cloud,
        output ready
    );

endinterface

[design/bcf_result_if.sv]
// ----------------------------------------------------------------------------
// bcf_result_if
// Result channel: valid/ready handshake carrying either an inside point index
// or a cloud summary.
// ----------------------------------------------------------------------------
interface bcf_result_if;
    import bcf_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [IndexBits-1:0] point_index;
    logic [CountBits-1:0] inside_count;
    logic [RmsBits-1:0]   rms_x;
    logic [RmsBits-1:0]   rms_y;
    logic [RmsBits-1:0]   rms_z;
    logic                 final_result;

    modport source (
        output valid, kind, point_index, inside_count, rms_x, rms_y, rms_z,
               final_result,
        input  ready
    );

    modport sink (
        input  valid, kind, point_index, inside_count, rms_x, rms_y, rms_z,
               final_result,
        output ready
    );

endinterface

[design/bcf_ctrl.sv]
// ----------------------------------------------------------------------------
// bcf_ctrl
// Sequencer: takes one point, evaluates it, accumulates, and on the last
// point of a cloud runs the serial divide and root before the summary.
// ----------------------------------------------------------------------------
module bcf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  bcf_pkg::status_t  status,
    output bcf_pkg::cmd_t     cmd
);
    import bcf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                // hold while an inside point finds the output word occupied
                if (!status.in_box)
                begin
                    state_next = ST_ACC;
                end
                else if (status.out_free)
                begin
                    cmd.push_index = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (status.last)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_done)
                begin
                    state_next = ST_SUMMARY;
                end
            end
            ST_SUMMARY:
            begin
                if (status.out_free)
                begin
                    cmd.push_summary = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[design/bcf_dp.sv]
// ----------------------------------------------------------------------------
// bcf_dp
// Datapath: box test, squares, saturating sums, position and count, three
// restoring dividers, three digit-by-digit square roots and the output word.
// ----------------------------------------------------------------------------
module bcf_dp #(
    parameter int MAX_POINTS = bcf_pkg::MaxPointsDefault
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  bcf_pkg::cmd_t                         cmd,
    output bcf_pkg::status_t                      status,
    input  logic signed [bcf_pkg::CoordBits-1:0]  coord_x,
    input  logic signed [bcf_pkg::CoordBits-1:0]  coord_y,
    input  logic signed [bcf_pkg::CoordBits-1:0]  coord_z,
    input  logic                                  end_of_cloud,
    input  logic [bcf_pkg::HalfBits-1:0]          half_x,
    input  logic [bcf_pkg::HalfBits-1:0]          half_y,
    input  logic [bcf_pkg::HalfBits-1:0]          half_z,
    bcf_result_if.source                          result
);
    import bcf_pkg::*;

    localparam int PosBits   = $clog2(MAX_POINTS + 1);
    localparam int IndexMax  = (1 << IndexBits) - 1;
    localparam int IdxCapInt = (MAX_POINTS - 1 < IndexMax) ? MAX_POINTS - 1 : IndexMax;
    localparam int SqBits    = 2 * CoordBits;
    localparam int RadBits   = 2 * RootBits;
    localparam int SremBits  = RootBits + 3;

    localparam logic [PosBits-1:0]   PosLimit   = PosBits'(MAX_POINTS);
    localparam logic [PosBits-1:0]   IdxCap     = PosBits'(IdxCapInt);
    localparam logic [CountBits-1:0] CountLimit = CountBits'(CountCap);
    localparam logic [SumBits-1:0]   SumMax     = '1;
    localparam logic [RmsBits-1:0]   RmsMax     = '1;
    localparam logic [StepBits-1:0]  DivLast    = StepBits'(DivSteps - 1);
    localparam logic [StepBits-1:0]  SqrtLast   = StepBits'(SqrtSteps - 1);

    // control state
    logic [PosBits-1:0]   pos_reg;
    logic [CountBits-1:0] count_reg;
    logic [SumBits-1:0]   sum_reg [NumAxes];
    logic [StepBits-1:0]  step_reg;
    logic                 out_valid_reg;

    // payload
    logic signed [CoordBits-1:0] coord_reg [NumAxes];
    logic                        last_reg;
    logic [SqBits-1:0]           sq_reg    [NumAxes];
    logic [CountBits-1:0]        rem_reg   [NumAxes];
    logic [SumBits-1:0]          quo_reg   [NumAxes];
    logic [RadBits-1:0]          rad_reg   [NumAxes];
    logic [RootBits:0]           srem_reg  [NumAxes];
    logic [RootBits-1:0]         root_reg  [NumAxes];

    kind_t                kind_reg;
    logic [IndexBits-1:0] index_reg;
    logic [CountBits-1:0] count_out_reg;
    logic [RmsBits-1:0]   rms_reg [NumAxes];
    logic                 final_reg;

    // combinational
    logic [HalfBits-1:0]  half      [NumAxes];
    logic [CoordBits-1:0] mag       [NumAxes];
    logic [NumAxes-1:0]   axis_in;
    logic                 take;
    logic [SumBits:0]     sum_wide  [NumAxes];
    logic [SumBits-1:0]   sum_next  [NumAxes];
    logic [SumBits-1:0]   sum_upd   [NumAxes];
    logic [CountBits:0]   trial     [NumAxes];
    logic [CountBits-1:0] rem_next  [NumAxes];
    logic [SumBits-1:0]   quo_next  [NumAxes];
    logic [SremBits-1:0]  srem_t    [NumAxes];
    logic [SremBits-1:0]  root_try  [NumAxes];
    logic [RootBits:0]    srem_next [NumAxes];
    logic [RootBits-1:0]  root_next [NumAxes];
    logic [RmsBits-1:0]   rms_val   [NumAxes];
    logic [PosBits-1:0]   idx;

    assign half[0] = half_x;
    assign half[1] = half_y;
    assign half[2] = half_z;

    assign take = (&axis_in) && (count_reg < CountLimit);
    assign idx  = (pos_reg > IdxCap) ? IdxCap : pos_reg;

    always_comb
    begin
        for (int a = 0; a < NumAxes; a++)
        begin
            mag[a] = coord_reg[a][CoordBits-1] ? CoordBits'(-coord_reg[a])
                                               : CoordBits'(coord_reg[a]);
            // strict bound on both sides: |c| < half
            axis_in[a] = (CoordBits + 1)'(mag[a]) < (CoordBits + 1)'(half[a]);

            sum_wide[a] = {1'b0, sum_reg[a]} + (SumBits + 1)'(sq_reg[a]);
            sum_next[a] = sum_wide[a][SumBits] ? SumMax : sum_wide[a][SumBits-1:0];
            sum_upd[a]  = take ? sum_next[a] : sum_reg[a];

            // restoring divide: shift one dividend bit into the remainder
            trial[a] = {rem_reg[a], quo_reg[a][SumBits-1]};
            if (trial[a] >= {1'b0, count_reg})
            begin
                rem_next[a] = CountBits'(trial[a] - {1'b0, count_reg});
                quo_next[a] = {quo_reg[a][SumBits-2:0], 1'b1};
            end
            else
            begin
                rem_next[a] = trial[a][CountBits-1:0];
                quo_next[a] = {quo_reg[a][SumBits-2:0], 1'b0};
            end

            // digit-by-digit root: bring down two radicand bits per step
            srem_t[a]   = {srem_reg[a], rad_reg[a][RadBits-1 -: 2]};
            root_try[a] = {1'b0, root_reg[a], 2'b01};
            if (srem_t[a] >= root_try[a])
            begin
                srem_next[a] = (RootBits + 1)'(srem_t[a] - root_try[a]);
                root_next[a] = {root_reg[a][RootBits-2:0], 1'b1};
            end
            else
            begin
                srem_next[a] = srem_t[a][RootBits:0];
                root_next[a] = {root_reg[a][RootBits-2:0], 1'b0};
            end

            if (count_reg == '0)
            begin
                rms_val[a] = '0;
            end
            else if (|root_reg[a][RootBits-1:RmsBits])
            begin
                rms_val[a] = RmsMax;
            end
            else
            begin
                rms_val[a] = root_reg[a][RmsBits-1:0];
            end
        end
    end

    always_comb
    begin
        status.in_box    = &axis_in;
        status.last      = last_reg;
        status.out_free  = !out_valid_reg || result.ready;
        status.div_done  = (step_reg == DivLast);
        status.sqrt_done = (step_reg == SqrtLast);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < NumAxes; a++)
            begin
                sum_reg[a] <= '0;
            end
        end
        else
        begin
            if (cmd.div_start || cmd.sqrt_start)
            begin
                step_reg <= '0;
            end
            else if (cmd.div_step || cmd.sqrt_step)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if (cmd.acc)
            begin
                if (pos_reg < PosLimit)
                begin
                    pos_reg <= pos_reg + 1'b1;
                end
                if (take)
                begin
                    count_reg <= count_reg + 1'b1;
                end
                for (int a = 0; a < NumAxes; a++)
                begin
                    sum_reg[a] <= sum_upd[a];
                end
            end

            // summary starts a new cloud
            if (cmd.push_summary)
            begin
                pos_reg   <= '0;
                count_reg <= '0;
                for (int a = 0; a < NumAxes; a++)
                begin
                    sum_reg[a] <= '0;
                end
            end

            if (cmd.push_index || cmd.push_summary)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            coord_reg[0] <= coord_x;
            coord_reg[1] <= coord_y;
            coord_reg[2] <= coord_z;
            last_reg     <= end_of_cloud;
        end

        for (int a = 0; a < NumAxes; a++)
        begin
            if (cmd.eval)
            begin
                sq_reg[a] <= SqBits'(mag[a]) * SqBits'(mag[a]);
            end

            if (cmd.div_start)
            begin
                rem_reg[a] <= '0;
                quo_reg[a] <= sum_upd[a];
            end
            else if (cmd.div_step)
            begin
                rem_reg[a] <= rem_next[a];
                quo_reg[a] <= quo_next[a];
            end

            // root starts from the quotient as the last divide step lands
            if (cmd.sqrt_start)
            begin
                rad_reg[a]  <= RadBits'(quo_next[a]);
                srem_reg[a] <= '0;
                root_reg[a] <= '0;
            end
            else if (cmd.sqrt_step)
            begin
                rad_reg[a]  <= rad_reg[a] << 2;
                srem_reg[a] <= srem_next[a];
                root_reg[a] <= root_next[a];
            end
        end

        if (cmd.push_index)
        begin
            kind_reg      <= KIND_INDEX;
            index_reg     <= IndexBits'(idx);
            count_out_reg <= '0;
            final_reg     <= !last_reg;
            for (int a = 0; a < NumAxes; a++)
            begin
                rms_reg[a] <= '0;
            end
        end
        else if (cmd.push_summary)
        begin
            kind_reg      <= KIND_SUMMARY;
            index_reg     <= '0;
            count_out_reg <= count_reg;
            final_reg     <= 1'b1;
            for (int a = 0; a < NumAxes; a++)
            begin
                rms_reg[a] <= rms_val[a];
            end
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.kind         = kind_reg;
    assign result.point_index  = index_reg;
    assign result.inside_count = count_out_reg;
    assign result.rms_x        = rms_reg[0];
    assign result.rms_y        = rms_reg[1];
    assign result.rms_z        = rms_reg[2];
    assign result.final_result = final_reg;

endmodule

[design/box_crop_filter_with_rms_top.sv]
// ----------------------------------------------------------------------------
// box_crop_filter_with_rms_top
// Axis-aligned crop box filter: emits the stream position of each inside
// point and, at end of cloud, the inside count and per-axis RMS.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake            word
//  -------   ---  -------------------  ----------------------------------------
//  point     in   valid/ready          coord_x, coord_y, coord_z, end_of_cloud
//  result    out  valid/ready          kind, point_index, inside_count,
//                                      rms_x, rms_y, rms_z, final_result
//  apb       in   psel/penable/pready  half_x @0x0, half_y @0x4, half_z @0x8
//
//  A point passes through capture, box test and square, and accumulate;
//  the box test holds while an inside point finds the output word occupied.
//  The last point of a cloud goes on to the serial divide (one quotient bit
//  per cycle) and serial square root (one root bit per cycle), then the summary.
//  Reset clears the position, count, sums, half extents and output valid flag.
//  A result word waits in its output register; an inside point or a summary
//  stalls only while the previous word is still not taken.
// ----------------------------------------------------------------------------
module box_crop_filter_with_rms_top #(
    parameter int MAX_POINTS = bcf_pkg::MaxPointsDefault
) (
    input  logic                              clk,
    input  logic                              rst_n,
    bcf_point_if.sink                         point,
    bcf_result_if.source                      result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bcf_pkg::CfgAddrBits-1:0]   paddr,
    input  logic [bcf_pkg::CfgDataBits-1:0]   pwdata,
    output logic [bcf_pkg::CfgDataBits-1:0]   prdata,
    output logic                              pready
);
    import bcf_pkg::*;

    logic [HalfBits-1:0]   half_x_reg;
    logic [HalfBits-1:0]   half_y_reg;
    logic [HalfBits-1:0]   half_z_reg;
    logic                  cfg_write;
    logic [RegIdxBits-1:0] reg_idx;
    cmd_t                  cmd;
    status_t               status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[CfgAddrBits-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_x_reg <= '0;
            half_y_reg <= '0;
            half_z_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                RegHalfX: half_x_reg <= pwdata[HalfBits-1:0];
                RegHalfY: half_y_reg <= pwdata[HalfBits-1:0];
                RegHalfZ: half_z_reg <= pwdata[HalfBits-1:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            RegHalfX: prdata = CfgDataBits'(half_x_reg);
            RegHalfY: prdata = CfgDataBits'(half_y_reg);
            RegHalfZ: prdata = CfgDataBits'(half_z_reg);
            default:  prdata = '0;
        endcase
    end

    bcf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (point.valid),
        .in_ready (point.ready),
        .status   (status),
        .cmd      (cmd)
    );

    bcf_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .coord_x      (point.coord_x),
        .coord_y      (point.coord_y),
        .coord_z      (point.coord_z),
        .end_of_cloud (point.end_of_cloud),
        .half_x       (half_x_reg),
        .half_y       (half_y_reg),
        .half_z       (half_z_reg),
        .result       (result)
    );

endmodule

[design/bcf_checker.sv]
// ----------------------------------------------------------------------------
// bcf_checker
// Port-level checks for the crop box filter, bound to the top level.
// ----------------------------------------------------------------------------
module bcf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          out_kind,
    input logic [bcf_pkg::IndexBits-1:0] out_point_index,
    input logic [bcf_pkg::CountBits-1:0] out_inside_count,
    input logic [bcf_pkg::RmsBits-1:0]   out_rms_x,
    input logic [bcf_pkg::RmsBits-1:0]   out_rms_y,
    input logic [bcf_pkg::RmsBits-1:0]   out_rms_z,
    input logic                          out_final
);
    import bcf_pkg::*;

    // hold a result word until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_kind) && $stable(out_point_index)
            && $stable(out_inside_count) && $stable(out_final))
        else $error("stalled result word changed");

    // one point at a time: a taken point closes the input for the next cycle
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("point accepted while the previous one is in work");

    a_summary_final: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_SUMMARY) |-> out_final && (out_point_index == '0))
        else $error("summary word without final mark or with an index");

    a_index_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_INDEX) |->
            (out_inside_count == '0) && (out_rms_x == '0) && (out_rms_y == '0)
            && (out_rms_z == '0))
        else $error("index word carries summary fields");

endmodule

bind box_crop_filter_with_rms_top bcf_checker u_bcf_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (point.valid),
    .in_ready         (point.ready),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .out_kind         (result.kind),
    .out_point_index  (result.point_index),
    .out_inside_count (result.inside_count),
    .out_rms_x        (result.rms_x),
    .out_rms_y        (result.rms_y),
    .out_rms_z        (result.rms_z),
    .out_final        (result.final_result)
);
